@@ src/lkv_pkg.sv @@
// Shared types and constants for the LFU key/value cache.
// No dependencies; used by lkv_ram users and lfu_key_value_cache_core.
package lkv_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 32;
  localparam int STAMP_W = 48;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 32'd1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ src/lkv_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/lfu_key_value_cache_core.sv @@
// Top level of the LFU key/value cache: sequencer, valid bits, scan trackers.
// Depends on lkv_pkg and lkv_ram (entry store).
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, opcode, lookup_key,   | to core
//          | put_value                                 |
//  out     | out_valid, out_ready, found, read_value   | from core
//  cfg     | cfg_wr_en, cfg_wr_data                    | to core
//
// Each beat runs through the states in order: in S_SCAN one entry per cycle
// is read from the entry RAM's single read port and scanned for a key match,
// the first free slot and the eviction victim, then S_DRAIN, S_WRITE for the
// write-back and S_FINISH to load the result register. in_ready is high only while
// the sequencer idles; a new beat may be taken while a result waits.
// Synchronous reset clears valid bits, occupancy and the stamp counter;
// the RAM needs no clearing pass.
module lfu_key_value_cache_core #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic signed [31:0]           lookup_key,
  input  logic signed [31:0]           put_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic signed [31:0]           read_value,
  input  logic                         cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0]    cfg_wr_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = (OW > lkv_pkg::CAP_W) ? OW : lkv_pkg::CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_LIMIT = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t state;

  logic [lkv_pkg::CAP_W-1:0]   capacity_in_use;
  logic [CAPACITY-1:0]         valid;
  logic [OW-1:0]               occupancy;
  logic [lkv_pkg::STAMP_W-1:0] stamp_counter;

  // captured beat
  logic                        op;
  logic [lkv_pkg::KEY_W-1:0]   key;
  logic [lkv_pkg::VALUE_W-1:0] val;

  // scan pipeline
  logic [IW-1:0] ridx;
  logic          pv;
  logic [IW-1:0] pidx;

  // scan trackers
  logic                        hit_found;
  logic [IW-1:0]               hit_idx;
  logic [lkv_pkg::VALUE_W-1:0] hit_val;
  logic [lkv_pkg::COUNT_W-1:0] hit_cnt;
  logic                        free_found;
  logic [IW-1:0]               free_idx;
  logic                        vic_found;
  logic [IW-1:0]               vic_idx;
  logic [lkv_pkg::COUNT_W-1:0] vic_cnt;
  logic [lkv_pkg::STAMP_W-1:0] vic_stamp;

  // RAM
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  lkv_pkg::entry_t             ram_wentry;
  logic [lkv_pkg::ENTRY_W-1:0] ram_rdata;
  lkv_pkg::entry_t             rentry;

  lkv_ram #(
    .WIDTH(lkv_pkg::ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wentry),
    .raddr(ridx),
    .rdata(ram_rdata)
  );

  assign rentry = lkv_pkg::entry_t'(ram_rdata);

  // write-back decision
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] cap_eff;
  logic [CW-1:0] occ_ext;
  logic          is_full;
  logic          do_insert;
  logic          use_free;
  logic [IW-1:0] ins_idx;
  logic [lkv_pkg::COUNT_W-1:0] cnt_inc;
  logic          scan_better;

  always_comb begin
    cap_ext   = CW'(capacity_in_use);
    cap_eff   = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;
    occ_ext   = CW'(occupancy);
    is_full   = (occ_ext >= cap_eff);
    use_free  = !is_full && free_found;
    ins_idx   = use_free ? free_idx : vic_idx;
    do_insert = (op == lkv_pkg::OP_PUT) && !hit_found && (cap_eff != '0);
    cnt_inc   = (hit_cnt == lkv_pkg::COUNT_MAX) ? hit_cnt : hit_cnt + 1'b1;

    ram_we     = 1'b0;
    ram_waddr  = hit_idx;
    ram_wentry.key   = key;
    ram_wentry.value = (op == lkv_pkg::OP_PUT) ? val : hit_val;
    ram_wentry.count = cnt_inc;
    ram_wentry.stamp = stamp_counter;
    if (state == S_WRITE) begin
      if (hit_found) begin
        ram_we = (op == lkv_pkg::OP_GET) || (cap_eff != '0);
      end else if (do_insert) begin
        ram_we           = 1'b1;
        ram_waddr        = ins_idx;
        ram_wentry.count = lkv_pkg::COUNT_ONE;
      end
    end

    // victim order: lower count, then older stamp; earlier index wins ties
    scan_better = !vic_found || (rentry.count < vic_cnt) ||
                  ((rentry.count == vic_cnt) && (rentry.stamp < vic_stamp));
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      capacity_in_use <= lkv_pkg::CAP_RESET;
      valid           <= '0;
      occupancy       <= '0;
      stamp_counter   <= '0;
      out_valid       <= 1'b0;
      pv              <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity_in_use <= cfg_wr_data;
      end
      // in S_FINISH the result load below owns out_valid
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      pv   <= (state == S_SCAN);
      pidx <= ridx;

      if (pv) begin
        if (valid[pidx] && (rentry.key == key) && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= pidx;
          hit_val   <= rentry.value;
          hit_cnt   <= rentry.count;
        end
        if (!valid[pidx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= pidx;
        end
        if (valid[pidx] && scan_better) begin
          vic_found <= 1'b1;
          vic_idx   <= pidx;
          vic_cnt   <= rentry.count;
          vic_stamp <= rentry.stamp;
        end
      end

      case (state)
        S_IDLE: begin
          ridx <= '0;
          if (in_valid) begin
            op         <= opcode;
            key        <= lookup_key;
            val        <= put_value;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            vic_found  <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ridx == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            ridx <= ridx + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (ram_we) begin
            stamp_counter <= stamp_counter + 1'b1;
          end
          if (!hit_found && do_insert) begin
            valid[ins_idx] <= 1'b1;
            if (use_free) begin
              occupancy <= occupancy + 1'b1;
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            found      <= hit_found;
            read_value <= (hit_found && (op == lkv_pkg::OP_GET)) ? hit_val : '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
